// ===== design/note_retrigger_voice_guard_assert.svh =====
// Assertion macros shared by the note retrigger guard RTL.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef NOTE_RETRIGGER_VOICE_GUARD_ASSERT_SVH
`define NOTE_RETRIGGER_VOICE_GUARD_ASSERT_SVH

// Same-cycle implication.
`define NRVG_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NRVG_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/nrvg_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants for the note retrigger guard.
// No dependencies; used by every module of the block.
package nrvg_pkg;

  localparam int PITCH_W    = 7;
  localparam int CHAN_W     = 4;
  localparam int VEL_W      = 7;
  localparam int SLOT_W     = PITCH_W + CHAN_W;
  localparam int NOTE_SLOTS = 1 << SLOT_W;
  localparam int OFF_W      = PITCH_W + CHAN_W;
  localparam int KEPT_W     = 1 + PITCH_W + CHAN_W + VEL_W;
  localparam int TDATA_W    = 24;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE,
    S_OFF_RD,
    S_OFF_LD,
    S_KEPT_RD,
    S_KEPT_LD
  } state_t;

  // Access request to the trigger count table.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_slot;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_slot;
  } tbl_req_t;

endpackage

// ===== design/nrvg_count_table.sv =====
`timescale 1ns / 1ps
// Trigger count table: one count per pitch and channel, registered read port.
// Depends on nrvg_pkg. Sweeps every entry to zero after reset.
module nrvg_count_table #(
  parameter int COUNT_WIDTH = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  nrvg_pkg::tbl_req_t     req,
  input  logic [COUNT_WIDTH-1:0] wr_data,
  output logic [COUNT_WIDTH-1:0] rd_data,
  output logic                   busy
);
  import nrvg_pkg::*;

  logic [COUNT_WIDTH-1:0] mem [NOTE_SLOTS];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [SLOT_W-1:0]      clr_idx_r;
  logic                   busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      busy_r    <= 1'b1;
    end else if (busy_r) begin
      clr_idx_r <= clr_idx_r + SLOT_W'(1);
      if (clr_idx_r == {SLOT_W{1'b1}}) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_slot];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// ===== design/nrvg_queue.sv =====
`timescale 1ns / 1ps
// Event queue storage: one write port at a given index, one registered read port.
// Depends on nrvg_pkg only for style; fill tracking lives with the sequencer.
module nrvg_queue #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 32,
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             push,
  input  logic [IW-1:0]    push_idx,
  input  logic [WIDTH-1:0] push_data,
  input  logic [IW-1:0]    rd_idx,
  output logic [WIDTH-1:0] rd_data
);
  import nrvg_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[push_idx] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/note_retrigger_voice_guard.sv =====
`timescale 1ns / 1ps
// Note retrigger guard: input item handshake, per-note count update and group emission.
// Depends on nrvg_pkg, nrvg_count_table, nrvg_queue and the assertion macro header.
//
// Usage: note events arrive on the in_ stream, one per beat. in_tuser is the note-on
// flag, in_tdata holds pitch, channel and velocity, in_tlast marks the last event of
// a simultaneous group. Results leave on the out_ stream in the same layout, with
// out_tlast on the final result of a group.
// Each event reads its count from the 2048-entry table when taken, then writes the
// updated count and queues the event in S_UPDATE. in_tready is low during that.
// When a group closes (in_tlast, or GROUP_MAX events taken), the block first emits
// the queued extra note-offs with velocity 0, then the kept events, each result by a
// queue read state and an output load state; in_tready stays low until the last one
// is loaded into the output register. A group with nothing kept emits nothing.
// A stalled receiver (out_tready low) holds the output register and pauses emission;
// the next event may be taken while the final result still waits.
// After reset the count table is swept to zero, one entry a cycle, all 2048 entries;
// in_tready is low during the sweep.
module note_retrigger_voice_guard #(
  parameter int GROUP_MAX   = 32,
  parameter int COUNT_WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [6:0] pitch, [10:7] channel, [17:11] velocity, [23:18] zero
  input  logic [nrvg_pkg::TDATA_W-1:0] in_tdata,
  // [0] note_on
  input  logic                         in_tuser,
  input  logic                         in_tlast,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [6:0] out_pitch, [10:7] out_channel, [17:11] out_velocity, [23:18] zero
  output logic [nrvg_pkg::TDATA_W-1:0] out_tdata,
  // [0] out_note_on
  output logic                         out_tuser,
  output logic                         out_tlast
);
  import nrvg_pkg::*;

  localparam int FW = $clog2(GROUP_MAX + 1);
  localparam int QW = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE = COUNT_WIDTH'(1);
  localparam logic [FW-1:0]          FILL_MAX  = FW'(GROUP_MAX);

  state_t state_r, state_nxt;

  logic               item_on_r, item_on_nxt;
  logic [PITCH_W-1:0] item_pitch_r, item_pitch_nxt;
  logic [CHAN_W-1:0]  item_chan_r, item_chan_nxt;
  logic [VEL_W-1:0]   item_vel_r, item_vel_nxt;
  logic               item_end_r, item_end_nxt;

  logic [FW-1:0] off_fill_r, off_fill_nxt;
  logic [FW-1:0] kept_fill_r, kept_fill_nxt;
  logic [FW-1:0] grp_cnt_r, grp_cnt_nxt;
  logic [QW-1:0] idx_r, idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_on_r, out_on_nxt;
  logic [PITCH_W-1:0] out_pitch_r, out_pitch_nxt;
  logic [CHAN_W-1:0]  out_chan_r, out_chan_nxt;
  logic [VEL_W-1:0]   out_vel_r, out_vel_nxt;
  logic               out_last_r, out_last_nxt;

  tbl_req_t               tbl_req;
  logic [COUNT_WIDTH-1:0] cnt_rd;
  logic [COUNT_WIDTH-1:0] cnt_new;
  logic                   tbl_busy;

  logic              off_push, kept_push, keep, retrig;
  logic [OFF_W-1:0]  off_rd;
  logic [KEPT_W-1:0] kept_rd;
  logic              in_acc, out_free, grp_close;
  logic [FW:0]       grp_cnt_inc;
  logic [FW-1:0]     off_fill_m1, kept_fill_m1;
  logic [FW-1:0]     idx_ext;

  nrvg_count_table #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_count_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (tbl_req),
    .wr_data(cnt_new),
    .rd_data(cnt_rd),
    .busy   (tbl_busy)
  );

  nrvg_queue #(
    .WIDTH(OFF_W),
    .DEPTH(GROUP_MAX)
  ) u_off_queue (
    .clk      (clk),
    .push     (off_push),
    .push_idx (off_fill_r[QW-1:0]),
    .push_data({item_pitch_r, item_chan_r}),
    .rd_idx   (idx_r),
    .rd_data  (off_rd)
  );

  nrvg_queue #(
    .WIDTH(KEPT_W),
    .DEPTH(GROUP_MAX)
  ) u_kept_queue (
    .clk      (clk),
    .push     (kept_push),
    .push_idx (kept_fill_r[QW-1:0]),
    .push_data({item_on_r, item_pitch_r, item_chan_r, item_vel_r}),
    .rd_idx   (idx_r),
    .rd_data  (kept_rd)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Count update: the single compare and increment/decrement unit for the table counts.
  always_comb begin
    cnt_new = cnt_rd;
    keep    = 1'b1;
    retrig  = 1'b0;
    if (cnt_rd == '0) begin
      if (item_on_r) begin
        cnt_new = COUNT_ONE;
      end
    end else if (item_on_r) begin
      retrig = 1'b1;
      if (cnt_rd != COUNT_MAX) begin
        cnt_new = cnt_rd + COUNT_ONE;
      end
    end else if (cnt_rd > COUNT_ONE) begin
      keep    = 1'b0;
      cnt_new = cnt_rd - COUNT_ONE;
    end else begin
      cnt_new = '0;
    end
  end

  assign off_push  = (state_r == S_UPDATE) && retrig && (off_fill_r < FILL_MAX);
  assign kept_push = (state_r == S_UPDATE) && keep && (kept_fill_r < FILL_MAX);

  assign grp_cnt_inc  = {1'b0, grp_cnt_r} + (FW + 1)'(1);
  assign grp_close    = item_end_r || (grp_cnt_inc >= (FW + 1)'(GROUP_MAX));
  assign off_fill_m1  = off_fill_r - FW'(1);
  assign kept_fill_m1 = kept_fill_r - FW'(1);
  assign idx_ext      = FW'(idx_r);

  always_comb begin
    tbl_req.rd_en   = in_acc;
    tbl_req.rd_slot = {in_tdata[6:0], in_tdata[10:7]};
    tbl_req.wr_en   = (state_r == S_UPDATE);
    tbl_req.wr_slot = {item_pitch_r, item_chan_r};
  end

  always_comb begin
    state_nxt      = state_r;
    item_on_nxt    = item_on_r;
    item_pitch_nxt = item_pitch_r;
    item_chan_nxt  = item_chan_r;
    item_vel_nxt   = item_vel_r;
    item_end_nxt   = item_end_r;
    off_fill_nxt   = off_fill_r;
    kept_fill_nxt  = kept_fill_r;
    grp_cnt_nxt    = grp_cnt_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_on_nxt     = out_on_r;
    out_pitch_nxt  = out_pitch_r;
    out_chan_nxt   = out_chan_r;
    out_vel_nxt    = out_vel_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      S_CLEAR: begin
        if (!tbl_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          item_on_nxt    = in_tuser;
          item_pitch_nxt = in_tdata[6:0];
          item_chan_nxt  = in_tdata[10:7];
          item_vel_nxt   = in_tdata[17:11];
          item_end_nxt   = in_tlast;
          state_nxt      = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (off_push) begin
          off_fill_nxt = off_fill_r + FW'(1);
        end
        if (kept_push) begin
          kept_fill_nxt = kept_fill_r + FW'(1);
        end
        idx_nxt = '0;
        if (!grp_close) begin
          grp_cnt_nxt = grp_cnt_inc[FW-1:0];
          state_nxt   = S_IDLE;
        end else begin
          grp_cnt_nxt = '0;
          if (off_fill_nxt != '0) begin
            state_nxt = S_OFF_RD;
          end else if (kept_fill_nxt != '0) begin
            state_nxt = S_KEPT_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OFF_RD: begin
        state_nxt = S_OFF_LD;
      end
      S_OFF_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_on_nxt    = 1'b0;
          out_pitch_nxt = off_rd[OFF_W-1:CHAN_W];
          out_chan_nxt  = off_rd[CHAN_W-1:0];
          out_vel_nxt   = '0;
          out_last_nxt  = (idx_ext == off_fill_m1) && (kept_fill_r == '0);
          if (idx_ext == off_fill_m1) begin
            idx_nxt = '0;
            if (kept_fill_r != '0) begin
              state_nxt = S_KEPT_RD;
            end else begin
              off_fill_nxt = '0;
              state_nxt    = S_IDLE;
            end
          end else begin
            idx_nxt   = idx_r + QW'(1);
            state_nxt = S_OFF_RD;
          end
        end
      end
      S_KEPT_RD: begin
        state_nxt = S_KEPT_LD;
      end
      S_KEPT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_on_nxt    = kept_rd[KEPT_W-1];
          out_pitch_nxt = kept_rd[KEPT_W-2:CHAN_W+VEL_W];
          out_chan_nxt  = kept_rd[CHAN_W+VEL_W-1:VEL_W];
          out_vel_nxt   = kept_rd[VEL_W-1:0];
          out_last_nxt  = (idx_ext == kept_fill_m1);
          if (idx_ext == kept_fill_m1) begin
            idx_nxt       = '0;
            off_fill_nxt  = '0;
            kept_fill_nxt = '0;
            state_nxt     = S_IDLE;
          end else begin
            idx_nxt   = idx_r + QW'(1);
            state_nxt = S_KEPT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      off_fill_r  <= '0;
      kept_fill_r <= '0;
      grp_cnt_r   <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      off_fill_r  <= off_fill_nxt;
      kept_fill_r <= kept_fill_nxt;
      grp_cnt_r   <= grp_cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_on_r    <= item_on_nxt;
    item_pitch_r <= item_pitch_nxt;
    item_chan_r  <= item_chan_nxt;
    item_vel_r   <= item_vel_nxt;
    item_end_r   <= item_end_nxt;
    out_on_r     <= out_on_nxt;
    out_pitch_r  <= out_pitch_nxt;
    out_chan_r   <= out_chan_nxt;
    out_vel_r    <= out_vel_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_on_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(TDATA_W - PITCH_W - CHAN_W - VEL_W){1'b0}},
                       out_vel_r, out_chan_r, out_pitch_r};

`include "note_retrigger_voice_guard_assert.svh"

  `NRVG_ASSERT_NOW(a_fill_bound, 1'b1, (off_fill_r <= FILL_MAX) && (kept_fill_r <= FILL_MAX), "queue fill above group size")
  `NRVG_ASSERT_NOW(a_clear_blocks, tbl_busy, !in_tready, "event taken during table clear")
  `NRVG_ASSERT_NEXT(a_accept_update, in_acc, state_r == S_UPDATE, "accepted event not updated")
  `NRVG_ASSERT_NOW(a_fill_vs_items, state_r == S_IDLE, (off_fill_r <= grp_cnt_r) && (kept_fill_r <= grp_cnt_r), "queue fill exceeds events taken in group")

endmodule
